FILE: design/grc_pkg.sv
`timescale 1ns / 1ps

package grc_pkg;

    // map and walk dimensions
    localparam int MAP_ROWS    = 64;
    localparam int MAP_COLS    = 64;
    localparam int TILE_PIXELS = 64;
    localparam int MAX_STEPS   = 128;

    localparam int MAP_DEPTH = MAP_ROWS * MAP_COLS;
    localparam int ADDR_W    = $clog2(MAP_DEPTH);
    localparam int MX_W      = $clog2(MAP_COLS);
    localparam int MY_W      = $clog2(MAP_ROWS);
    localparam int STEP_W    = $clog2(MAX_STEPS + 1);

    // one tile in Q.8 pixels, a power of two
    localparam int SPAN    = TILE_PIXELS * 256;
    localparam int SPAN_W  = $clog2(SPAN + 1);
    localparam int SPAN_SH = $clog2(SPAN);
    localparam int FS_W    = SPAN_W + 32;

    // shared divider sizing
    localparam int DIV_W = 32;
    localparam int NB_W  = $clog2(DIV_W + 1);

    // fixed point limits and constants
    localparam int RAY_LIM   = 1048575;
    localparam int CAM_ONE   = 16384;
    localparam int NEAR_DIST = 65536;
    localparam logic [31:0] DIST_MAX = 32'hFFFF_FFFF;
    localparam logic [6:0]  SHADE_X  = 7'd50;
    localparam logic [6:0]  SHADE_Y  = 7'd70;

    // register indexes
    localparam logic [2:0] REG_PLAYER_X = 3'd0;
    localparam logic [2:0] REG_PLAYER_Y = 3'd1;
    localparam logic [2:0] REG_DIR_X    = 3'd2;
    localparam logic [2:0] REG_DIR_Y    = 3'd3;
    localparam logic [2:0] REG_PLANE_X  = 3'd4;
    localparam logic [2:0] REG_PLANE_Y  = 3'd5;
    localparam logic [2:0] REG_WIDTH    = 3'd6;
    localparam logic [2:0] REG_HEIGHT   = 3'd7;

    // item modes
    localparam logic MODE_WRITE = 1'b0;
    localparam logic MODE_CAST  = 1'b1;

    typedef enum logic [4:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_CAM,
        ST_CAM_W,
        ST_MUL,
        ST_RAY,
        ST_DX,
        ST_DX_W,
        ST_DY,
        ST_DY_W,
        ST_PX,
        ST_CHK,
        ST_SX,
        ST_STEP,
        ST_LOOK,
        ST_HT_W,
        ST_FIN
    } state_t;

    typedef struct packed {
        logic              start;
        logic [DIV_W-1:0]  dividend;
        logic [31:0]       divisor;
        logic [NB_W-1:0]   nbits;
    } div_req_t;

    typedef struct packed {
        logic              done;
        logic [DIV_W-1:0]  quot;
    } div_rsp_t;

endpackage

FILE: design/grc_div.sv
`timescale 1ns / 1ps

module grc_div
(
    input  logic              clk,
    input  logic              rst_n,
    input  grc_pkg::div_req_t req,
    output grc_pkg::div_rsp_t rsp
);
    import grc_pkg::*;

    logic [DIV_W-1:0] q_reg;
    logic [31:0]      r_reg;
    logic [31:0]      d_reg;
    logic [NB_W-1:0]  cnt_reg;
    logic             busy_reg;
    logic             done_reg;
    logic [32:0]      trial;
    logic             fits;

    // one quotient bit per cycle
    assign trial = {r_reg, q_reg[DIV_W-1]};
    assign fits  = trial >= {1'b0, d_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= req.nbits;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == NB_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // payload, left aligned so only nbits iterations are needed
    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            q_reg <= req.dividend << (NB_W'(DIV_W) - req.nbits);
            r_reg <= '0;
            d_reg <= req.divisor;
        end
        else if (busy_reg)
        begin
            q_reg <= {q_reg[DIV_W-2:0], fits};
            r_reg <= fits ? 32'(trial - {1'b0, d_reg}) : trial[31:0];
        end
    end

    assign rsp.done = done_reg;
    assign rsp.quot = q_reg;

endmodule

FILE: design/grid_ray_cast_column.sv
`timescale 1ns / 1ps

// Casts one screen column into a 64 x 64 tile map held in an internal RAM.
// A cell write request is written while the block stays idle. A cast
// request runs up to four divisions on one shared radix-2 divider (screen
// offset, two reciprocals, wall height); a reciprocal is skipped when its
// ray component is zero and the height division when the wall is within
// one tile. The tile split of the viewer position is a shift and the first
// side distances a multiply and a shift, one state each; each grid step
// takes one state for the step and map RAM read and one for the hit test,
// for up to MAX_STEPS steps. After reset the map RAM is cleared one cell a
// cycle, during which input requests stall; configuration writes are taken
// at any time but must only be issued while the block is idle. A finished
// result waits in an output register while the next request runs.

module grid_ray_cast_column
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        mode,
    input  logic [5:0]  cell_row,
    input  logic [5:0]  cell_col,
    input  logic [7:0]  cell_value,
    input  logic [10:0] screen_column,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [10:0] column_out,
    output logic [10:0] wall_top,
    output logic [11:0] wall_height,
    output logic        hit_side,
    output logic [7:0]  wall_kind,
    output logic [6:0]  shade,
    output logic        ran_out,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [19:0] cfg_data
);
    import grc_pkg::*;

    state_t state_reg, state_next;

    // configuration
    logic [19:0]        player_x_reg, player_y_reg;
    logic signed [15:0] dir_x_reg, dir_y_reg, plane_x_reg, plane_y_reg;
    logic [11:0]        width_reg, height_reg;

    // cast datapath
    logic [10:0]        col_reg;
    logic signed [27:0] cam_reg;
    logic signed [43:0] prod_x_reg, prod_y_reg;
    logic signed [20:0] rx_reg, ry_reg;
    logic [31:0]        dx_reg, dy_reg, sdx_reg, sdy_reg;
    logic [19:0]        mxq_reg, myq_reg;
    logic [SPAN_W-1:0]  offx_reg, offy_reg;
    logic [MX_W-1:0]    mx_reg;
    logic [MY_W-1:0]    my_reg;
    logic [STEP_W-1:0]  n_reg;
    logic               side_reg, hit_reg;
    logic [7:0]         kind_reg;
    logic [11:0]        ht_reg;

    // map memory
    logic [7:0]         tile_mem [MAP_DEPTH];
    logic [7:0]         rd_data_reg;
    logic [ADDR_W-1:0]  clr_reg;
    logic               we;
    logic [ADDR_W-1:0]  wa;
    logic [7:0]         wd;
    logic               re;
    logic [ADDR_W-1:0]  ra;

    // output register
    logic               ov_reg;
    logic [10:0]        o_col_reg, o_top_reg;
    logic [11:0]        o_ht_reg;
    logic               o_side_reg, o_run_reg;
    logic [7:0]         o_kind_reg;
    logic [6:0]         o_shade_reg;

    div_req_t dreq;
    div_rsp_t drsp;

    logic               acc;
    logic [11:0]        w_eff;
    logic [30:0]        sum_x, sum_y;
    logic [19:0]        abs_x, abs_y;
    logic [FS_W-1:0]    fsx, fsy;
    logic               step_x, blocked;
    logic [MX_W-1:0]    mx_n;
    logic [MY_W-1:0]    my_n;
    logic [32:0]        sum_sd;
    logic [31:0]        sd_new, perp_dist;
    logic               out_free;
    logic [11:0]        top_full;

    grc_div u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (dreq),
        .rsp   (drsp)
    );

    assign acc      = in_valid && !in_stall;
    assign w_eff    = (width_reg == 12'd0) ? 12'd1 : width_reg;
    assign out_free = !ov_reg || !out_stall;

    // ray components with saturation
    assign sum_x = {{15{dir_x_reg[15]}}, dir_x_reg} + {prod_x_reg[43], prod_x_reg[43:14]};
    assign sum_y = {{15{dir_y_reg[15]}}, dir_y_reg} + {prod_y_reg[43], prod_y_reg[43:14]};
    assign abs_x = rx_reg[20] ? 20'(-rx_reg) : rx_reg[19:0];
    assign abs_y = ry_reg[20] ? 20'(-ry_reg) : ry_reg[19:0];

    // first side distances, offset times delta over one tile
    assign fsx = FS_W'(offx_reg) * FS_W'(dx_reg);
    assign fsy = FS_W'(offy_reg) * FS_W'(dy_reg);

    // grid step choice, ties go to y
    assign step_x  = sdx_reg < sdy_reg;
    assign blocked = step_x
        ? (rx_reg[20] ? (mx_reg == '0) : (mx_reg == MX_W'(MAP_COLS - 1)))
        : (ry_reg[20] ? (my_reg == '0) : (my_reg == MY_W'(MAP_ROWS - 1)));
    assign mx_n = !step_x ? mx_reg : (rx_reg[20] ? mx_reg - 1'b1 : mx_reg + 1'b1);
    assign my_n = step_x ? my_reg : (ry_reg[20] ? my_reg - 1'b1 : my_reg + 1'b1);
    assign sum_sd = step_x ? ({1'b0, sdx_reg} + {1'b0, dx_reg})
                           : ({1'b0, sdy_reg} + {1'b0, dy_reg});
    assign sd_new = sum_sd[32] ? DIST_MAX : sum_sd[31:0];
    assign perp_dist = side_reg ? (sdy_reg - dy_reg) : (sdx_reg - dx_reg);
    assign top_full = (height_reg - ht_reg) >> 1;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_CLEAR;
        else
            state_reg <= state_next;
    end

    // next state, divider requests and memory control
    always_comb
    begin
        state_next    = state_reg;
        in_stall      = 1'b1;
        dreq.start    = 1'b0;
        dreq.dividend = '0;
        dreq.divisor  = 32'd1;
        dreq.nbits    = NB_W'(1);
        we = 1'b0;
        wa = clr_reg;
        wd = 8'd0;
        re = 1'b0;
        ra = ADDR_W'(my_n) * ADDR_W'(MAP_COLS) + ADDR_W'(mx_n);
        unique case (state_reg)
            ST_CLEAR:
            begin
                we = 1'b1;
                if (clr_reg == ADDR_W'(MAP_DEPTH - 1))
                    state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                in_stall = 1'b0;
                if (acc && mode == MODE_WRITE)
                begin
                    we = (32'(cell_row) < MAP_ROWS) && (32'(cell_col) < MAP_COLS);
                    wa = ADDR_W'(cell_row) * ADDR_W'(MAP_COLS) + ADDR_W'(cell_col);
                    wd = cell_value;
                end
                else if (acc)
                    state_next = ST_CAM;
            end
            ST_CAM:
            begin
                dreq.start    = 1'b1;
                dreq.dividend = DIV_W'({col_reg, 15'd0});
                dreq.divisor  = 32'(w_eff);
                dreq.nbits    = NB_W'(26);
                state_next    = ST_CAM_W;
            end
            ST_CAM_W: if (drsp.done) state_next = ST_MUL;
            ST_MUL:   state_next = ST_RAY;
            ST_RAY:   state_next = ST_DX;
            ST_DX:
            begin
                if (abs_x == 20'd0)
                    state_next = ST_DY;
                else
                begin
                    dreq.start    = 1'b1;
                    dreq.dividend = DIV_W'(1) << 30;
                    dreq.divisor  = 32'(abs_x);
                    dreq.nbits    = NB_W'(31);
                    state_next    = ST_DX_W;
                end
            end
            ST_DX_W: if (drsp.done) state_next = ST_DY;
            ST_DY:
            begin
                if (abs_y == 20'd0)
                    state_next = ST_PX;
                else
                begin
                    dreq.start    = 1'b1;
                    dreq.dividend = DIV_W'(1) << 30;
                    dreq.divisor  = 32'(abs_y);
                    dreq.nbits    = NB_W'(31);
                    state_next    = ST_DY_W;
                end
            end
            ST_DY_W: if (drsp.done) state_next = ST_PX;
            ST_PX:   state_next = ST_CHK;
            ST_CHK:
            begin
                if (32'(mxq_reg) >= MAP_COLS || 32'(myq_reg) >= MAP_ROWS)
                    state_next = ST_FIN;
                else
                    state_next = ST_SX;
            end
            ST_SX:   state_next = ST_STEP;
            ST_STEP:
            begin
                if (n_reg == STEP_W'(MAX_STEPS) || blocked)
                    state_next = ST_FIN;
                else
                begin
                    re         = 1'b1;
                    state_next = ST_LOOK;
                end
            end
            ST_LOOK:
            begin
                if (rd_data_reg == 8'd0)
                    state_next = ST_STEP;
                else if (perp_dist > 32'(NEAR_DIST))
                begin
                    dreq.start    = 1'b1;
                    dreq.dividend = DIV_W'({height_reg, 16'd0});
                    dreq.divisor  = perp_dist;
                    dreq.nbits    = NB_W'(28);
                    state_next    = ST_HT_W;
                end
                else
                    state_next = ST_FIN;
            end
            ST_HT_W: if (drsp.done) state_next = ST_FIN;
            ST_FIN:  if (out_free) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    // map memory, one write or one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (we)
            tile_mem[wa] <= wd;
        if (re)
            rd_data_reg <= tile_mem[ra];
    end

    // clearing pass counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            clr_reg <= '0;
        else if (state_reg == ST_CLEAR)
            clr_reg <= clr_reg + 1'b1;
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            player_x_reg <= '0;
            player_y_reg <= '0;
            dir_x_reg    <= 16'sd16384;
            dir_y_reg    <= '0;
            plane_x_reg  <= '0;
            plane_y_reg  <= 16'sd10813;
            width_reg    <= 12'd640;
            height_reg   <= 12'd480;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_PLAYER_X: player_x_reg <= cfg_data;
                REG_PLAYER_Y: player_y_reg <= cfg_data;
                REG_DIR_X:    dir_x_reg    <= cfg_data[15:0];
                REG_DIR_Y:    dir_y_reg    <= cfg_data[15:0];
                REG_PLANE_X:  plane_x_reg  <= cfg_data[15:0];
                REG_PLANE_Y:  plane_y_reg  <= cfg_data[15:0];
                REG_WIDTH:    width_reg    <= cfg_data[11:0];
                REG_HEIGHT:   height_reg   <= cfg_data[11:0];
                default:      ;
            endcase
        end
    end

    // walk control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            n_reg    <= '0;
            side_reg <= 1'b0;
            hit_reg  <= 1'b0;
        end
        else
        begin
            case (state_reg)
                ST_CAM:
                begin
                    n_reg    <= '0;
                    side_reg <= 1'b0;
                    hit_reg  <= 1'b0;
                end
                ST_STEP:
                begin
                    if (n_reg != STEP_W'(MAX_STEPS))
                        side_reg <= !step_x;
                    if (n_reg != STEP_W'(MAX_STEPS) && !blocked)
                        n_reg <= n_reg + 1'b1;
                end
                ST_LOOK:
                    if (rd_data_reg != 8'd0)
                        hit_reg <= 1'b1;
                default: ;
            endcase
        end
    end

    // cast datapath
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                col_reg <= screen_column;
                ht_reg  <= '0;
                kind_reg <= '0;
                dx_reg  <= DIST_MAX;
                dy_reg  <= DIST_MAX;
            end
            ST_CAM_W:
                if (drsp.done)
                    cam_reg <= $signed({1'b0, drsp.quot[26:0]}) - 28'sd16384;
            ST_MUL:
            begin
                prod_x_reg <= plane_x_reg * cam_reg;
                prod_y_reg <= plane_y_reg * cam_reg;
            end
            ST_RAY:
            begin
                if ($signed(sum_x) > 31'sd1048575)
                    rx_reg <= 21'sd1048575;
                else if ($signed(sum_x) < -31'sd1048575)
                    rx_reg <= -21'sd1048575;
                else
                    rx_reg <= sum_x[20:0];
                if ($signed(sum_y) > 31'sd1048575)
                    ry_reg <= 21'sd1048575;
                else if ($signed(sum_y) < -31'sd1048575)
                    ry_reg <= -21'sd1048575;
                else
                    ry_reg <= sum_y[20:0];
            end
            ST_DX_W: if (drsp.done) dx_reg <= drsp.quot[31:0];
            ST_DY_W: if (drsp.done) dy_reg <= drsp.quot[31:0];
            // viewer tile and offset to the next grid line, tile is a power of two
            ST_PX:
            begin
                mxq_reg  <= 20'(player_x_reg >> SPAN_SH);
                myq_reg  <= 20'(player_y_reg >> SPAN_SH);
                offx_reg <= rx_reg[20] ? SPAN_W'(player_x_reg[SPAN_SH-1:0])
                                       : SPAN_W'(SPAN) - SPAN_W'(player_x_reg[SPAN_SH-1:0]);
                offy_reg <= ry_reg[20] ? SPAN_W'(player_y_reg[SPAN_SH-1:0])
                                       : SPAN_W'(SPAN) - SPAN_W'(player_y_reg[SPAN_SH-1:0]);
            end
            ST_CHK:
            begin
                mx_reg <= mxq_reg[MX_W-1:0];
                my_reg <= myq_reg[MY_W-1:0];
            end
            ST_SX:
            begin
                sdx_reg <= fsx[SPAN_SH+31:SPAN_SH];
                sdy_reg <= fsy[SPAN_SH+31:SPAN_SH];
            end
            ST_STEP:
                if (n_reg != STEP_W'(MAX_STEPS) && !blocked)
                begin
                    mx_reg <= mx_n;
                    my_reg <= my_n;
                    if (step_x)
                        sdx_reg <= sd_new;
                    else
                        sdy_reg <= sd_new;
                end
            ST_LOOK:
                if (rd_data_reg != 8'd0)
                begin
                    kind_reg <= rd_data_reg;
                    ht_reg   <= height_reg;
                end
            ST_HT_W: if (drsp.done) ht_reg <= drsp.quot[11:0];
            default: ;
        endcase
    end

    // output register valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ov_reg <= 1'b0;
        else if (state_reg == ST_FIN && out_free)
            ov_reg <= 1'b1;
        else if (!out_stall)
            ov_reg <= 1'b0;
    end

    // output payload
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_FIN && out_free)
        begin
            o_col_reg   <= col_reg;
            o_side_reg  <= side_reg;
            o_shade_reg <= side_reg ? SHADE_Y : SHADE_X;
            o_run_reg   <= !hit_reg;
            o_kind_reg  <= hit_reg ? kind_reg : 8'd0;
            o_ht_reg    <= hit_reg ? ht_reg : 12'd0;
            o_top_reg   <= hit_reg ? top_full[10:0] : height_reg[11:1];
        end
    end

    assign cfg_ready   = 1'b1;
    assign out_valid   = ov_reg;
    assign column_out  = o_col_reg;
    assign wall_top    = o_top_reg;
    assign wall_height = o_ht_reg;
    assign hit_side    = o_side_reg;
    assign wall_kind   = o_kind_reg;
    assign shade       = o_shade_reg;
    assign ran_out     = o_run_reg;

endmodule

FILE: design/grc_checker.sv
`timescale 1ns / 1ps

module grc_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_stall,
    input logic        mode,
    input logic        out_valid,
    input logic        out_stall,
    input logic [11:0] wall_height,
    input logic        hit_side,
    input logic [7:0]  wall_kind,
    input logic [6:0]  shade,
    input logic        ran_out
);
    import grc_pkg::*;

    // a held result stays offered
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result dropped while stalled");

    // a cast request occupies the block
    a_cast_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && mode == MODE_CAST |=> in_stall)
        else $error("request taken during a cast");

    // no wall means no slice
    a_ran_out: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && ran_out |-> wall_height == 12'd0 && wall_kind == 8'd0)
        else $error("ran out result carries a wall");

    // shade follows the side
    a_shade: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> shade == (hit_side ? SHADE_Y : SHADE_X))
        else $error("shade does not match side");

endmodule

bind grid_ray_cast_column grc_checker u_grc_checker
(
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .mode        (mode),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .wall_height (wall_height),
    .hit_side    (hit_side),
    .wall_kind   (wall_kind),
    .shade       (shade),
    .ran_out     (ran_out)
);

FILE: dv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import grc_pkg::*;

    localparam int WATCHDOG_LIMIT = 40000;
    localparam int DRAIN_CYCLES   = 600;
    localparam logic [7:0] FREE_CELL = 8'd0;

    typedef struct {
        logic        mode;
        logic [5:0]  row;
        logic [5:0]  col;
        logic [7:0]  value;
        logic [10:0] scol;
    } map_req_t;

    typedef struct {
        logic [10:0] col;
        logic [10:0] top;
        logic [11:0] height;
        logic        side;
        logic [7:0]  kind;
        logic [6:0]  shade;
        logic        ran;
    } slice_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic        mode;
    logic [5:0]  cell_row;
    logic [5:0]  cell_col;
    logic [7:0]  cell_value;
    logic [10:0] screen_column;
    logic        out_valid;
    logic        out_stall;
    logic [10:0] column_out;
    logic [10:0] wall_top;
    logic [11:0] wall_height;
    logic        hit_side;
    logic [7:0]  wall_kind;
    logic [6:0]  shade;
    logic        ran_out;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [2:0]  cfg_index;
    logic [19:0] cfg_data;

    grid_ray_cast_column dut (.*);

    // shadow of the block's registers and tile map
    longint     pos_x, pos_y, view_dx, view_dy, cam_px, cam_py, scr_w, scr_h;
    logic [7:0] tiles [MAP_ROWS*MAP_COLS];

    map_req_t pending_reqs[$];
    map_req_t cur_req;
    slice_t   slices_due[$];
    int       send_idle_pct, recv_stall_pct;
    int       fail_count;
    int       quiet_cycles;

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic longint ray_of(longint d, longint p, longint cam);
        longint r;
        r = d + ((p * cam) >>> 14);
        if (r > RAY_LIM) r = RAY_LIM;
        if (r < -RAY_LIM) r = -RAY_LIM;
        return r;
    endfunction

    function automatic longint recip_of(longint r);
        longint a;
        a = (r < 0) ? -r : r;
        return (a == 0) ? longint'(DIST_MAX) : (longint'(1) << 30) / a;
    endfunction

    function automatic longint first_cross(longint pos, longint tile, bit neg, longint dl);
        longint off;
        off = neg ? pos - tile * SPAN : tile * SPAN + SPAN - pos;
        return (off * dl) / SPAN;
    endfunction

    function automatic longint sat_sum(longint a, longint b);
        return (a + b > longint'(DIST_MAX)) ? longint'(DIST_MAX) : a + b;
    endfunction

    // walk the grid for one screen column
    function automatic slice_t cast_column(logic [10:0] scol);
        slice_t res;
        longint w, cam, rx, ry, dlx, dly, mx, my, stx, sty, sdx, sdy, nx, ny;
        longint hit_dist, ht, tp;
        bit     side, hit;
        logic [7:0] v;
        w    = (scr_w == 0) ? 1 : scr_w;
        cam  = (2 * longint'(scol) * CAM_ONE) / w - CAM_ONE;
        rx   = ray_of(view_dx, cam_px, cam);
        ry   = ray_of(view_dy, cam_py, cam);
        dlx  = recip_of(rx);
        dly  = recip_of(ry);
        mx   = (pos_x >> 8) / TILE_PIXELS;
        my   = (pos_y >> 8) / TILE_PIXELS;
        stx  = (rx < 0) ? -1 : 1;
        sty  = (ry < 0) ? -1 : 1;
        side = 1'b0;
        hit  = 1'b0;
        v    = FREE_CELL;
        hit_dist = 0;
        if (mx < MAP_COLS && my < MAP_ROWS)
        begin
            sdx = first_cross(pos_x, mx, rx < 0, dlx);
            sdy = first_cross(pos_y, my, ry < 0, dly);
            for (int n = 0; n < MAX_STEPS; n++)
            begin
                nx = mx;
                ny = my;
                if (sdx < sdy)
                begin
                    nx += stx;
                    side = 1'b0;
                end
                else
                begin
                    ny += sty;
                    side = 1'b1;
                end
                if (nx < 0 || ny < 0 || nx >= MAP_COLS || ny >= MAP_ROWS)
                    break;
                mx = nx;
                my = ny;
                if (side) sdy = sat_sum(sdy, dly);
                else sdx = sat_sum(sdx, dlx);
                v = tiles[my * MAP_COLS + mx];
                if (v > FREE_CELL)
                begin
                    hit  = 1'b1;
                    hit_dist = side ? sdy - dly : sdx - dlx;
                    break;
                end
            end
        end
        ht = 0;
        if (hit)
        begin
            ht = (hit_dist > NEAR_DIST) ? (scr_h * 65536) / hit_dist : scr_h;
            tp = (scr_h - ht) / 2;
        end
        else
            tp = scr_h / 2;
        res.col    = scol;
        res.top    = tp[10:0];
        res.height = ht[11:0];
        res.side   = side;
        res.kind   = hit ? v : 8'd0;
        res.shade  = side ? SHADE_Y : SHADE_X;
        res.ran    = !hit;
        return res;
    endfunction

    // request driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid      <= 1'b0;
            mode          <= MODE_WRITE;
            cell_row      <= '0;
            cell_col      <= '0;
            cell_value    <= '0;
            screen_column <= '0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                if (cur_req.mode == MODE_WRITE)
                    tiles[cur_req.row * MAP_COLS + cur_req.col] = cur_req.value;
                else
                    slices_due.push_back(cast_column(cur_req.scol));
            end
            if (!(in_valid && in_stall))
            begin
                if (pending_reqs.size() > 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    cur_req = pending_reqs.pop_front();
                    in_valid      <= 1'b1;
                    mode          <= cur_req.mode;
                    cell_row      <= cur_req.row;
                    cell_col      <= cur_req.col;
                    cell_value    <= cur_req.value;
                    screen_column <= cur_req.scol;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    task automatic check_field(string name, int exp_v, int act_v);
        if (exp_v != act_v)
        begin
            $error("%s mismatch: expected %0d, got %0d", name, exp_v, act_v);
            fail_count++;
        end
    endtask

    // result monitor
    always @(posedge clk or negedge rst_n)
    begin
        slice_t e;
        if (!rst_n)
            out_stall <= 1'b0;
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (slices_due.size() == 0)
                begin
                    $error("result for column %0d with no request waiting", column_out);
                    fail_count++;
                end
                else
                begin
                    e = slices_due.pop_front();
                    check_field("column_out", int'(e.col), int'(column_out));
                    check_field("wall_top", int'(e.top), int'(wall_top));
                    check_field("wall_height", int'(e.height), int'(wall_height));
                    check_field("hit_side", int'(e.side), int'(hit_side));
                    check_field("wall_kind", int'(e.kind), int'(wall_kind));
                    check_field("shade", int'(e.shade), int'(shade));
                    check_field("ran_out", int'(e.ran), int'(ran_out));
                end
            end
            out_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles == WATCHDOG_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    task automatic write_reg(logic [2:0] idx, logic [19:0] data);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
        case (idx)
            REG_PLAYER_X: pos_x   = longint'(data);
            REG_PLAYER_Y: pos_y   = longint'(data);
            REG_DIR_X:    view_dx = longint'($signed(data[15:0]));
            REG_DIR_Y:    view_dy = longint'($signed(data[15:0]));
            REG_PLANE_X:  cam_px  = longint'($signed(data[15:0]));
            REG_PLANE_Y:  cam_py  = longint'($signed(data[15:0]));
            REG_WIDTH:    scr_w   = longint'(data[11:0]);
            default:      scr_h   = longint'(data[11:0]);
        endcase
        cfg_valid <= 1'b0;
    endtask

    task automatic set_view(logic [19:0] px, logic [19:0] py, logic [15:0] dx, logic [15:0] dy,
                            logic [15:0] plx, logic [15:0] ply, logic [11:0] w, logic [11:0] h);
        write_reg(REG_PLAYER_X, px);
        write_reg(REG_PLAYER_Y, py);
        write_reg(REG_DIR_X, {4'd0, dx});
        write_reg(REG_DIR_Y, {4'd0, dy});
        write_reg(REG_PLANE_X, {4'd0, plx});
        write_reg(REG_PLANE_Y, {4'd0, ply});
        write_reg(REG_WIDTH, {8'd0, w});
        write_reg(REG_HEIGHT, {8'd0, h});
    endtask

    function automatic void add_write(int r, int c, int v);
        map_req_t q;
        q.mode  = MODE_WRITE;
        q.row   = 6'(r);
        q.col   = 6'(c);
        q.value = 8'(v);
        q.scol  = 11'($urandom_range(2047));
        pending_reqs.push_back(q);
    endfunction

    function automatic void add_cast(int sc);
        map_req_t q;
        q.mode  = MODE_CAST;
        q.row   = 6'($urandom_range(63));
        q.col   = 6'($urandom_range(63));
        q.value = 8'($urandom_range(255));
        q.scol  = 11'(sc);
        pending_reqs.push_back(q);
    endfunction

    task automatic drain;
        while (pending_reqs.size() > 0 || in_valid || slices_due.size() > 0)
            @(posedge clk);
        // a trailing cell write gives no result, let it settle
        repeat (40) @(posedge clk);
    endtask

    initial
    begin
        int pct_send [4] = '{0, 49, 0, 25};
        int pct_recv [4] = '{0, 0, 49, 25};
        rst_n = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = REG_PLAYER_X;
        cfg_data = '0;
        fail_count = 0;
        quiet_cycles = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        pos_x = 0; pos_y = 0; view_dx = 16384; view_dy = 0;
        cam_px = 0; cam_py = 10813; scr_w = 640; scr_h = 480;
        foreach (tiles[i]) tiles[i] = FREE_CELL;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // directed: map corners, wall ring pieces, column extremes
        add_cast(0);
        add_write(0, 0, 0);
        add_write(63, 63, 255);
        add_write(32, 40, 1);
        add_write(32, 24, 7);
        add_write(40, 32, 200);
        add_write(24, 32, 128);
        add_write(0, 63, 85);
        add_write(63, 0, 170);
        add_cast(0);
        add_cast(320);
        add_cast(639);
        add_cast(2047);
        add_cast(1000);
        drain();
        // viewer near center, looking along +x and along +y, near a wall too
        set_view(20'h80080, 20'h80080, 16'h4000, 16'h0000, 16'h0000, 16'h2A3D, 12'd640, 12'd480);
        add_cast(0); add_cast(320); add_cast(639); add_cast(2047);
        drain();
        set_view(20'h9FF00, 20'h80080, 16'h0000, 16'h4000, 16'h4000, 16'h0000, 12'd0, 12'd4095);
        add_cast(0); add_cast(1); add_cast(2047);
        drain();
        // zero ray: no direction, no plane
        set_view(20'h12345, 20'hFFFFF, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 12'd1, 12'd0);
        add_cast(0); add_cast(5);
        drain();

        for (int ph = 0; ph < 8; ph++)
        begin
            send_idle_pct  = pct_send[ph % 4];
            recv_stall_pct = pct_recv[ph % 4];
            case (ph)
                0: set_view(20'h00000, 20'h00000, 16'h8000, 16'h7FFF, 16'h7FFF, 16'h8000,
                            12'hFFF, 12'd1);
                1: set_view(20'hFFFFF, 20'hFFFFF, 16'h7FFF, 16'h8000, 16'h8000, 16'h7FFF,
                            12'd2048, 12'd2048);
                default: set_view(20'($urandom_range(20'hFFFFF)), 20'($urandom_range(20'hFFFFF)),
                                  16'($urandom_range(16'hFFFF)), 16'($urandom_range(16'hFFFF)),
                                  16'($urandom_range(16'hFFFF)), 16'($urandom_range(16'hFFFF)),
                                  12'($urandom_range(1, 2048)), 12'($urandom_range(1, 2048)));
            endcase
            for (int k = 0; k < 60; k++)
            begin
                if ($urandom_range(99) < 40)
                    add_write(int'($urandom_range(63)), int'($urandom_range(63)),
                              ($urandom_range(9) == 0) ? 0 : int'($urandom_range(1, 255)));
                else if ($urandom_range(9) == 0)
                    add_cast(int'($urandom_range(2047)));
                else
                    add_cast(int'($urandom_range((scr_w > 0 && scr_w <= 2048)
                                                 ? int'(scr_w - 1) : 2047)));
            end
            drain();
        end

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0 && slices_due.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
